// ===== hw/rtl/lgr_pkg.sv =====
// lgr_pkg: shared types and constants of the life generation row engine.
// No dependencies; every other file of the block depends on it.
package lgr_pkg;

  localparam int ROW_W      = 64;  // bits in one grid row on the channels
  localparam int GW_W       = 7;   // grid_width register width
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int NBR_CNT_W  = 4;   // holds 0..8 live neighbors

  localparam logic [GW_W-1:0]      GRID_WIDTH_RESET = 7'd64;
  localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT      = 4'd3;
  localparam logic [NBR_CNT_W-1:0] SURVIVE_COUNT    = 4'd2;

  // Register word index (paddr[2])
  localparam logic REG_GRID_WIDTH = 1'b0;

  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    row_t next_cells;
    logic frame_end;
  } result_t;

  // Control from the row sequencer to the result buffer
  typedef struct packed {
    logic push;
    logic frame_end;
  } out_req_t;

  // Status back from the result buffer
  typedef struct packed {
    logic skid_full;
  } out_sts_t;

endpackage

// ===== hw/rtl/lgr_ifs.sv =====
// lgr_in_if / lgr_out_if: valid/ready channels of the life row engine.
// Depends on lgr_pkg for the row type.
interface lgr_in_if;
  logic          valid;
  logic          ready;
  lgr_pkg::row_t row_cells;
  logic          final_row;

  modport source (output valid, row_cells, final_row, input ready);
  modport sink   (input valid, row_cells, final_row, output ready);
endinterface

interface lgr_out_if;
  logic          valid;
  logic          ready;
  lgr_pkg::row_t next_cells;
  logic          frame_end;

  modport source (output valid, next_cells, frame_end, input ready);
  modport sink   (input valid, next_cells, frame_end, output ready);
endinterface

// ===== hw/rtl/lgr_lane.sv =====
// lgr_lane: B3/S23 rule for one cell from its eight neighbors.
// Depends on lgr_pkg for the rule constants.
module lgr_lane (
  input  logic       self_alive,
  input  logic [7:0] nbr,
  input  logic       col_active,
  output logic       next_alive
);
  import lgr_pkg::*;

  logic [NBR_CNT_W-1:0] cnt;

  always_comb begin
    cnt        = NBR_CNT_W'($countones(nbr));
    next_alive = col_active &&
                 ((cnt == BIRTH_COUNT) || ((cnt == SURVIVE_COUNT) && self_alive));
  end

endmodule

// ===== hw/rtl/lgr_out_stage.sv =====
// lgr_out_stage: merges lane bits into a result row and buffers it in an
// output register plus one skid entry. Depends on lgr_pkg and lgr_out_if.
module lgr_out_stage #(
  parameter int LANES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [LANES-1:0]  lane_bits,
  input  lgr_pkg::out_req_t req,
  output lgr_pkg::out_sts_t sts,
  lgr_out_if.source         out_chan
);
  import lgr_pkg::*;

  result_t new_res;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  logic    pop;

  // merge lanes, upper columns stay dead
  always_comb begin
    new_res                        = '0;
    new_res.next_cells[LANES-1:0]  = lane_bits;
    new_res.frame_end              = req.frame_end;
  end

  assign pop = out_valid_r && out_chan.ready;

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = req.push;
        if (req.push) begin
          skid_nxt = new_res;
        end
      end else begin
        out_valid_nxt = req.push;
        if (req.push) begin
          out_nxt = new_res;
        end
      end
    end else if (req.push) begin
      skid_nxt       = new_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign sts.skid_full      = skid_valid_r;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.next_cells = out_r.next_cells;
  assign out_chan.frame_end  = out_r.frame_end;

`ifndef SYNTHESIS
  // the sequencer must never push into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    req.push |-> !skid_valid_r)
    else $error("result pushed while skid entry full");

  // skid only fills behind a waiting output
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // a stalled result with a full skid keeps both
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_chan.ready) |=> (skid_valid_r && out_valid_r))
    else $error("buffered result lost under stall");
`endif

endmodule

// ===== hw/rtl/life_generation_row_engine.sv =====
// life_generation_row_engine: one B3/S23 Life generation, one row per request.
// Depends on lgr_pkg, lgr_ifs (channels), lgr_lane and lgr_out_stage.
//
// Usage:
//  - in_chan carries one grid row per request (row_cells, bit c = column c)
//    and final_row marking the bottom row. out_chan returns next-generation
//    rows (next_cells) with frame_end set on the bottom row's result.
//  - The first row of a frame gives no result. Every later row gives the
//    result for the row above it, pushed into the result buffer on accept.
//  - A final row also needs its own result: the engine flushes (input not
//    ready) to compute it once the skid entry has room, then clears its row
//    store. Otherwise one row/cycle, while the skid entry is not full.
//  - Columns at or beyond grid_width (clamped to MAX_WIDTH) are dead, on
//    input and output. grid_width sits at APB word 0, reset 64.
//  - The result path is an output register plus one skid entry, so a row
//    is accepted while a finished result waits; input ready drops only when
//    the skid entry is full or a flush is pending.
//  - Reset (rst_n low, synchronous) clears the row store, the buffer and
//    restores grid_width to 64. Write grid_width only when idle.
module life_generation_row_engine #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lgr_in_if.sink                           in_chan,
  lgr_out_if.source                        out_chan,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [lgr_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [lgr_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [lgr_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import lgr_pkg::*;

  localparam int LW = MAX_WIDTH;

  // ---------------- configuration ----------------
  logic [GW_W-1:0] gw_r, gw_nxt;
  logic [LW-1:0]   mask_r, mask_nxt;
  logic [GW_W-1:0] gw_clamp;
  logic            cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == REG_GRID_WIDTH);

  always_comb begin
    gw_nxt   = cfg_pwdata[GW_W-1:0];
    gw_clamp = (gw_nxt > GW_W'(MAX_WIDTH)) ? GW_W'(MAX_WIDTH) : gw_nxt;
    for (int c = 0; c < LW; c++) begin
      mask_nxt[c] = (GW_W'(c) < gw_clamp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r   <= GRID_WIDTH_RESET;
      mask_r <= '1;
    end else if (cfg_wr) begin
      gw_r   <= gw_nxt;
      mask_r <= mask_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_GRID_WIDTH) ?
                      CFG_DATA_W'(gw_r) : '0;

  // ---------------- row sequencer ----------------
  logic [LW-1:0] upper_r, upper_nxt;
  logic [LW-1:0] middle_r, middle_nxt;
  logic          seen_r, seen_nxt;    // a row of this frame is stored
  logic          flush_r, flush_nxt;  // bottom row result still owed
  logic [LW-1:0] row_m;
  logic          acc;
  out_req_t      req;
  out_sts_t      sts;

  assign row_m         = in_chan.row_cells[LW-1:0] & mask_r;
  assign in_chan.ready = !flush_r && !sts.skid_full;
  assign acc           = in_chan.valid && in_chan.ready;

  always_comb begin
    upper_nxt  = upper_r;
    middle_nxt = middle_r;
    seen_nxt   = seen_r;
    flush_nxt  = flush_r;
    req.push      = 1'b0;
    req.frame_end = flush_r;
    if (flush_r) begin
      // emit bottom row (dead row below), then clear the frame
      if (!sts.skid_full) begin
        req.push   = 1'b1;
        upper_nxt  = '0;
        middle_nxt = '0;
        seen_nxt   = 1'b0;
        flush_nxt  = 1'b0;
      end
    end else if (acc) begin
      req.push   = seen_r;
      upper_nxt  = seen_r ? middle_r : '0;
      middle_nxt = row_m;
      seen_nxt   = 1'b1;
      flush_nxt  = in_chan.final_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r  <= '0;
      middle_r <= '0;
      seen_r   <= 1'b0;
      flush_r  <= 1'b0;
    end else begin
      upper_r  <= upper_nxt;
      middle_r <= middle_nxt;
      seen_r   <= seen_nxt;
      flush_r  <= flush_nxt;
    end
  end

  // ---------------- lanes ----------------
  // padded rows give dead neighbors past both edges
  logic [LW+1:0] above_p, mid_p, below_p;
  logic [LW-1:0] lane_bits;

  assign above_p = {1'b0, upper_r, 1'b0};
  assign mid_p   = {1'b0, middle_r, 1'b0};
  assign below_p = {1'b0, (flush_r ? {LW{1'b0}} : row_m), 1'b0};

  for (genvar c = 0; c < LW; c++) begin : g_lane
    lgr_lane u_lane (
      .self_alive (middle_r[c]),
      .nbr        ({above_p[c+2:c], below_p[c+2:c], mid_p[c+2], mid_p[c]}),
      .col_active (mask_r[c]),
      .next_alive (lane_bits[c])
    );
  end

  // ---------------- merge and result buffer ----------------
  lgr_out_stage #(
    .LANES (LW)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_bits (lane_bits),
    .req       (req),
    .sts       (sts),
    .out_chan  (out_chan)
  );

`ifndef SYNTHESIS
  a_flush_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> !in_chan.ready)
    else $error("input ready during bottom-row flush");

  a_final_sets_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_chan.final_row) |=> flush_r)
    else $error("final row did not schedule a flush");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (flush_r && !sts.skid_full) |=> (!flush_r && !seen_r && middle_r == '0 &&
                                     upper_r == '0))
    else $error("row store not cleared after flush");

  a_first_row_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !seen_r) |-> !req.push)
    else $error("result pushed for first row of frame");
`endif

endmodule
